// ----- rtl/aes_pkg.sv -----
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned Rounds = 10;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  typedef struct packed {
    logic [HalfW-1:0] block_high;
    logic [HalfW-1:0] block_low;
    logic [MaskW-1:0] keep;
    logic [MaskW-1:0] strb;
    logic             last;
    logic             user;
    logic             id;
    logic             dest;
  } in_word_t;

  typedef struct packed {
    logic [HalfW-1:0] cipher_high;
    logic [HalfW-1:0] cipher_low;
    logic [MaskW-1:0] out_keep;
    logic [MaskW-1:0] out_strb;
    logic             out_last;
    logic             out_user;
    logic             out_id;
    logic             out_dest;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [HalfW-1:0]   data;
  } cfg_word_t;

  typedef struct packed {
    logic [BlockW-1:0] state;
    logic [BlockW-1:0] rkey;
    logic [MaskW-1:0]  keep;
    logic [MaskW-1:0]  strb;
    logic              last;
    logic              user;
    logic              id;
    logic              dest;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd0: v = 8'h01;
      4'd1: v = 8'h02;
      4'd2: v = 8'h04;
      4'd3: v = 8'h08;
      4'd4: v = 8'h10;
      4'd5: v = 8'h20;
      4'd6: v = 8'h40;
      4'd7: v = 8'h80;
      4'd8: v = 8'h1b;
      4'd9: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[BlockW-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[BlockW-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[BlockW-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // Next round key from the previous one; r counts from 0.
  function automatic logic [BlockW-1:0] next_key(input logic [BlockW-1:0] k,
                                                 input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- rtl/aes_if.sv -----
interface aes_in_if;
  logic               valid;
  logic               ready;
  aes_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aes_out_if;
  logic               valid;
  logic               ready;
  aes_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aes_cfg_if;
  logic               valid;
  logic               ready;
  aes_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/aes128_block_encrypt_top.sv -----
// AES-128 encryptor: one 128-bit word per cycle while the output is not stalled,
// 11 pipeline stages (initial AddRoundKey, then one stage per round). A taken
// word is registered in stage 0 and moves through the round stages in order;
// the last stage is the output register and holds the ciphertext until taken.
// Each word carries its own round key down the pipe: stage 0
// latches the key registers, and every later stage derives its round key from
// the previous stage's one. A key write therefore applies to the very next word
// taken, with no settle time. The whole pipeline advances together when the
// output stage is empty or taken; sideband fields ride along with the state.
module aes128_block_encrypt_top (
  input  logic clk,
  input  logic rst_n,
  aes_in_if.sink    in_ch,
  aes_out_if.source out_ch,
  aes_cfg_if.sink   cfg_ch
);

  localparam int unsigned Stages = aes_pkg::Rounds + 1;

  logic [aes_pkg::HalfW-1:0]  key_high_r, key_low_r;
  logic [aes_pkg::BlockW-1:0] rk_nxt [Stages];
  logic [Stages-1:0]          vld_r;
  aes_pkg::stage_t            stg_r [Stages];
  logic                       adv;

  assign cfg_ch.ready = 1'b1;

  // Hold the key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.index == aes_pkg::RegKeyHigh) key_high_r <= cfg_ch.data.data;
      if (cfg_ch.data.index == aes_pkg::RegKeyLow)  key_low_r  <= cfg_ch.data.data;
    end
  end

  // Round keys: stage r expands the key carried by stage r-1 by one step.
  always_comb begin
    rk_nxt[0] = {key_high_r, key_low_r};
    for (int r = 1; r < Stages; r++) begin
      rk_nxt[r] = aes_pkg::next_key(stg_r[r-1].rkey, 4'(r - 1));
    end
  end

  // Advance the pipe while the output slot is free or being taken.
  assign adv         = !vld_r[Stages-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Stages-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0].state <= {in_ch.data.block_high, in_ch.data.block_low} ^ rk_nxt[0];
      stg_r[0].rkey  <= rk_nxt[0];
      stg_r[0].keep  <= in_ch.data.keep;
      stg_r[0].strb  <= in_ch.data.strb;
      stg_r[0].last  <= in_ch.data.last;
      stg_r[0].user  <= in_ch.data.user;
      stg_r[0].id    <= in_ch.data.id;
      stg_r[0].dest  <= in_ch.data.dest;
      for (int r = 1; r < Stages; r++) begin
        stg_r[r].rkey <= rk_nxt[r];
        stg_r[r].keep <= stg_r[r-1].keep;
        stg_r[r].strb <= stg_r[r-1].strb;
        stg_r[r].last <= stg_r[r-1].last;
        stg_r[r].user <= stg_r[r-1].user;
        stg_r[r].id   <= stg_r[r-1].id;
        stg_r[r].dest <= stg_r[r-1].dest;
        if (r == Stages - 1) begin
          stg_r[r].state <= aes_pkg::sub_shift(stg_r[r-1].state) ^ rk_nxt[r];
        end else begin
          stg_r[r].state <= aes_pkg::mix_columns(aes_pkg::sub_shift(stg_r[r-1].state))
                            ^ rk_nxt[r];
        end
      end
    end
  end

  assign out_ch.valid            = vld_r[Stages-1];
  assign out_ch.data.cipher_high = stg_r[Stages-1].state[127:64];
  assign out_ch.data.cipher_low  = stg_r[Stages-1].state[63:0];
  assign out_ch.data.out_keep    = stg_r[Stages-1].keep;
  assign out_ch.data.out_strb    = stg_r[Stages-1].strb;
  assign out_ch.data.out_last    = stg_r[Stages-1].last;
  assign out_ch.data.out_user    = stg_r[Stages-1].user;
  assign out_ch.data.out_id      = stg_r[Stages-1].id;
  assign out_ch.data.out_dest    = stg_r[Stages-1].dest;

endmodule

// ----- tb/sv/tb_aes128_block_encrypt_top.sv -----
`timescale 1ns / 100ps

module tb_aes128_block_encrypt_top;

  logic clk;
  logic rst_n;

  aes_in_if  in_ch ();
  aes_out_if out_ch ();
  aes_cfg_if cfg_ch ();

  aes128_block_encrypt_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Predictor key, tracks every accepted register write.
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;

  aes_pkg::out_word_t cipher_fifo[$];
  int        fail_count;
  bit        hold_out;   // request a long receiver stall
  int        hold_len;

  localparam logic [7:0] SBOX_TBL [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam logic [7:0] RCON_TBL [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte-array form of FIPS-197 encryption; byte 0 is the MSB of the block.
  function automatic logic [127:0] cipher_block(input logic [127:0] pt,
                                                input logic [127:0] key);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] rk [176];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3, al;
    logic [127:0] ct;
    for (int i = 0; i < 16; i++) begin
      st[i] = pt[127-8*i -: 8];
      rk[i] = key[127-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        f = w[0];
        w[0] = SBOX_TBL[w[1]] ^ RCON_TBL[i/4-1];
        w[1] = SBOX_TBL[w[2]];
        w[2] = SBOX_TBL[w[3]];
        w[3] = SBOX_TBL[f];
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[r+4*c] = SBOX_TBL[st[r+4*((c+r)%4)]];
      st = tmp;
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
    return ct;
  endfunction

  // Clock and the single reset pulse.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int pick_gap();
    // mostly short gaps, now and then a long one
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Receiver: random ready, plus a long counted stall on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < hold_len; i++) @(posedge clk);
        hold_out = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted ciphertext word with the oldest expectation.
  always @(posedge clk) begin
    aes_pkg::out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cipher_fifo.size() == 0) begin
        report_mismatch("unexpected word", out_ch.data.cipher_high, 64'h0);
      end else begin
        want = cipher_fifo.pop_front();
        if (out_ch.data.cipher_high !== want.cipher_high)
          report_mismatch("cipher_high", out_ch.data.cipher_high, want.cipher_high);
        if (out_ch.data.cipher_low !== want.cipher_low)
          report_mismatch("cipher_low", out_ch.data.cipher_low, want.cipher_low);
        if (out_ch.data.out_keep !== want.out_keep)
          report_mismatch("keep", 64'(out_ch.data.out_keep), 64'(want.out_keep));
        if (out_ch.data.out_strb !== want.out_strb)
          report_mismatch("strb", 64'(out_ch.data.out_strb), 64'(want.out_strb));
        if (out_ch.data.out_last !== want.out_last)
          report_mismatch("last", 64'(out_ch.data.out_last), 64'(want.out_last));
        if (out_ch.data.out_user !== want.out_user)
          report_mismatch("user", 64'(out_ch.data.out_user), 64'(want.out_user));
        if (out_ch.data.out_id !== want.out_id)
          report_mismatch("id", 64'(out_ch.data.out_id), 64'(want.out_id));
        if (out_ch.data.out_dest !== want.out_dest)
          report_mismatch("dest", 64'(out_ch.data.out_dest), 64'(want.out_dest));
      end
    end
  end

  // Offer one plaintext word, hold until taken, then queue its ciphertext.
  task automatic send_block(input aes_pkg::in_word_t w, input bit no_gap = 1'b0);
    aes_pkg::out_word_t exp_w;
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk iff in_ch.ready);
    {exp_w.cipher_high, exp_w.cipher_low} =
      cipher_block({w.block_high, w.block_low}, {key_hi_q, key_lo_q});
    exp_w.out_keep = w.keep;
    exp_w.out_strb = w.strb;
    exp_w.out_last = w.last;
    exp_w.out_user = w.user;
    exp_w.out_id   = w.id;
    exp_w.out_dest = w.dest;
    cipher_fifo.push_back(exp_w);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for the pipeline to drain, then idle.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk iff cipher_fifo.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  // Write one key register while the block is idle.
  task automatic write_key(input logic [aes_pkg::CfgIdxW-1:0] idx,
                           input logic [63:0] val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= val;
    @(posedge clk iff cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == aes_pkg::RegKeyHigh) key_hi_q = val;
    else key_lo_q = val;
    // leave cfg_ch idle before returning; data may follow right after
    @(posedge clk);
  endtask

  function automatic aes_pkg::in_word_t rand_block();
    aes_pkg::in_word_t w;
    w.block_high = {$urandom, $urandom};
    w.block_low  = {$urandom, $urandom};
    w.keep = 16'($urandom);
    w.strb = 16'($urandom);
    {w.last, w.user, w.id, w.dest} = 4'($urandom);
    return w;
  endfunction

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Zero key, never written: the all-zero key must be in use after reset.
  task automatic test_reset_key();
    aes_pkg::in_word_t w;
    w = '0;
    send_block(w);
    w = '1;
    send_block(w);
    wait_drain();
  endtask

  // FIPS-197 vector plus field extremes.
  task automatic test_directed();
    aes_pkg::in_word_t w;
    write_key(aes_pkg::RegKeyHigh, 64'h0001020304050607);
    write_key(aes_pkg::RegKeyLow,  64'h08090a0b0c0d0e0f);
    w = '0;
    w.block_high = 64'h0011223344556677;
    w.block_low  = 64'h8899aabbccddeeff;
    send_block(w, 1'b1);
    w = '0;
    send_block(w);
    w = '1;
    send_block(w);
    w = '0;
    w.keep = 16'hffff; w.last = 1'b1; w.id = 1'b1;
    send_block(w);
    w = '0;
    w.strb = 16'hffff; w.user = 1'b1; w.dest = 1'b1;
    w.block_high = 64'h8000000000000000; w.block_low = 64'h1;
    send_block(w);
    wait_drain();
    write_key(aes_pkg::RegKeyHigh, '1);
    write_key(aes_pkg::RegKeyLow, '1);
    w = '0;
    send_block(w, 1'b1);
    w = '1;
    send_block(w);
    wait_drain();
    write_key(aes_pkg::RegKeyHigh, 64'h0);
    write_key(aes_pkg::RegKeyLow, 64'h0);
    send_block(rand_block());
    wait_drain();
  endtask

  // Back-to-back words at full rate with no sender gaps.
  task automatic test_full_rate();
    for (int i = 0; i < 40; i++) send_block(rand_block(), 1'b1);
    wait_drain();
  endtask

  // Long receiver stall while the sender keeps offering: the block must fill
  // and push back on its input.
  task automatic test_backpressure();
    hold_len = 120;
    hold_out = 1'b1;
    for (int i = 0; i < 40; i++) send_block(rand_block(), 1'b1);
    wait_drain();
  endtask

  // Random keys in several phases, random words with random gaps.
  task automatic test_random();
    for (int ph = 0; ph < 12; ph++) begin
      write_key(aes_pkg::RegKeyHigh, rand_half());
      write_key(aes_pkg::RegKeyLow, rand_half());
      for (int i = 0; i < 100; i++) begin
        send_block(rand_block());
        if ($urandom_range(0, 63) == 0) drop_valid();
      end
      // pause the sender until every ciphertext word is back
      wait_drain();
    end
  endtask

  initial begin
    fail_count = 0;
    hold_out = 1'b0;
    hold_len = 0;
    key_hi_q = '0;
    key_lo_q = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    @(posedge clk iff rst_n);
    test_reset_key();
    test_directed();
    test_full_rate();
    test_backpressure();
    test_random();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && cipher_fifo.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/aes_pkg.sv
rtl/aes_if.sv
rtl/aes128_block_encrypt_top.sv
tb/sv/tb_aes128_block_encrypt_top.sv
